// ===== src/rms_pkg.sv =====
package rms_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned PROD_W  = 2 * FIELD_W;

	// One stored record, packed with the primary key in the top bits.
	typedef struct packed {
		logic [FIELD_W-1:0] points;
		logic [FIELD_W-1:0] scored;
		logic [FIELD_W-1:0] conceded;
		logic [FIELD_W-1:0] record_id;
	} record_t;

endpackage

// ===== src/rms_if.sv =====
// Input channel: one record per transfer, last_in closes the set.
interface rms_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] points;
	logic [15:0] scored;
	logic [15:0] conceded;
	logic [15:0] record_id;
	logic        last_in;

	modport source (output valid, points, scored, conceded, record_id, last_in, input ready);
	modport sink   (input valid, points, scored, conceded, record_id, last_in, output ready);
endinterface

// Output channel: one sorted record per transfer.
interface rms_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_points;
	logic [15:0] out_scored;
	logic [15:0] out_conceded;
	logic [15:0] out_id;
	logic        last_out;
	logic        dropped;

	modport source (output valid, out_points, out_scored, out_conceded, out_id, last_out,
		dropped, input ready);
	modport sink   (input valid, out_points, out_scored, out_conceded, out_id, last_out,
		dropped, output ready);
endinterface

// ===== src/rms_cmp.sv =====
// Shared record comparator. The ratio cross-products are registered, so the
// heads must be held for one cycle before goes_first is valid.
module rms_cmp (
	input  logic             clk,
	input  rms_pkg::record_t head_l,
	input  rms_pkg::record_t head_r,
	output logic             goes_first
);
	import rms_pkg::*;

	logic [FIELD_W-1:0] den_l;
	logic [FIELD_W-1:0] den_r;
	logic [PROD_W-1:0]  prod_l_s1;
	logic [PROD_W-1:0]  prod_r_s1;

	// A conceded count of zero makes the ratio equal to the scored count.
	assign den_l = (head_l.conceded == '0) ? FIELD_W'(1) : head_l.conceded;
	assign den_r = (head_r.conceded == '0) ? FIELD_W'(1) : head_r.conceded;

	always_ff @(posedge clk) begin
		prod_l_s1 <= PROD_W'(head_l.scored) * PROD_W'(den_r);
		prod_r_s1 <= PROD_W'(head_r.scored) * PROD_W'(den_l);
	end

	always_comb begin
		if (head_l.points != head_r.points) begin
			goes_first = head_l.points > head_r.points;
		end else if (prod_l_s1 != prod_r_s1) begin
			goes_first = prod_l_s1 > prod_r_s1;
		end else if (head_l.scored != head_r.scored) begin
			goes_first = head_l.scored > head_r.scored;
		end else begin
			goes_first = head_l.record_id <= head_r.record_id;
		end
	end

endmodule

// ===== src/multikey_record_merge_sort_top.sv =====
// Records load one per transfer; the record that closes the set starts the sort (or, for a
// set of one, the output). The sort runs ceil(log2 n) passes; each record is fetched and
// compared through the single read port of the ping-pong memories and the shared comparator.
// Results leave one at a time; each is held until the sink takes it before the next is read.
// Reset clears the record count, the overflow mark and all control state; the memories
// are not cleared, since only entries written in the current set are ever read.
module multikey_record_merge_sort_top #(
	parameter int unsigned MAX_RECORDS = 64
) (
	input  logic clk,
	input  logic arst_n,
	rms_in_if.sink     records,
	rms_out_if.source  sorted
);
	import rms_pkg::*;

	// Index width for the memories, count width that can hold MAX_RECORDS itself,
	// and a wider sum width for run bounds such as lo + 2w before they are clipped.
	localparam int unsigned AW     = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_RECORDS + 1);
	localparam int unsigned SW     = CNT_W + 2;

	typedef enum logic [8:0] {
		ST_LOAD      = 9'b000000001,
		ST_SEG       = 9'b000000010,
		ST_FETCH     = 9'b000000100,
		ST_CAPTURE   = 9'b000001000,
		ST_PROD      = 9'b000010000,
		ST_MERGE     = 9'b000100000,
		ST_EMIT_RD   = 9'b001000000,
		ST_EMIT_WAIT = 9'b010000000,
		ST_EMIT_HOLD = 9'b100000000
	} state_t;

	state_t state_q;

	// Set bookkeeping.
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;

	// Merge control: run width, pair start, run bounds and the three cursors.
	// src_q selects the memory that holds the current pass; the other one is written.
	logic             src_q;
	logic [SW-1:0]    w_q;
	logic [SW-1:0]    lo_q;
	logic [SW-1:0]    mid_q;
	logic [SW-1:0]    hi_q;
	logic [SW-1:0]    i_q;
	logic [SW-1:0]    j_q;
	logic [SW-1:0]    k_q;
	logic             need_l_q;
	logic             need_r_q;
	logic [CNT_W-1:0] emit_idx_q;

	// Run heads feeding the comparator, and the output register.
	record_t head_l_q;
	record_t head_r_q;
	record_t out_rec_q;
	logic    out_last_q;
	logic    out_valid_q;

	// Two record memories used in ping-pong fashion, one read port each.
	record_t mem0 [MAX_RECORDS];
	record_t mem1 [MAX_RECORDS];
	record_t rd0_q;
	record_t rd1_q;

	logic          in_fire;
	logic          stored;
	logic [SW-1:0] n_ext;
	logic [SW-1:0] seg_mid;
	logic [SW-1:0] seg_hi;
	logic [SW-1:0] sum_mid;
	logic [SW-1:0] sum_hi;
	logic [SW-1:0] lo_next;
	logic [SW-1:0] w_next;
	logic [SW-1:0] i_next;
	logic [SW-1:0] j_next;
	logic [SW-1:0] k_next;
	logic          goes_first;
	logic          take_left;
	record_t       in_rec;
	record_t       rd_data;
	record_t       wr_data;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          we0;
	logic          we1;

	rms_cmp u_cmp (
		.clk        (clk),
		.head_l     (head_l_q),
		.head_r     (head_r_q),
		.goes_first (goes_first)
	);

	// Input side: records are taken only while the block is loading a set.
	assign records.ready = (state_q == ST_LOAD);
	assign in_fire       = records.valid && records.ready;
	assign stored        = (count_q < CNT_W'(MAX_RECORDS));

	assign in_rec.points    = records.points;
	assign in_rec.scored    = records.scored;
	assign in_rec.conceded  = records.conceded;
	assign in_rec.record_id = records.record_id;

	// Run bounds of the next pair, clipped to the set size. A pair whose right run
	// is empty is merged all the same, which simply copies the left run across.
	assign n_ext   = SW'(count_q);
	assign sum_mid = lo_q + w_q;
	assign sum_hi  = lo_q + (w_q << 1);
	assign seg_mid = (sum_mid < n_ext) ? sum_mid : n_ext;
	assign seg_hi  = (sum_hi < n_ext) ? sum_hi : n_ext;
	assign lo_next = sum_hi;
	assign w_next  = w_q << 1;
	assign i_next  = i_q + SW'(1);
	assign j_next  = j_q + SW'(1);
	assign k_next  = k_q + SW'(1);

	// Key ties go to the lower record_id; the left head wins only when the ids are equal too.
	assign take_left = (i_q < mid_q) && ((j_q >= hi_q) || goes_first);

	assign rd_data = src_q ? rd1_q : rd0_q;

	always_comb begin
		if (state_q == ST_FETCH) begin
			rd_addr = need_l_q ? i_q[AW-1:0] : j_q[AW-1:0];
		end else begin
			rd_addr = emit_idx_q[AW-1:0];
		end
	end

	always_comb begin
		if (state_q == ST_MERGE) begin
			wr_addr = k_q[AW-1:0];
			wr_data = take_left ? head_l_q : head_r_q;
		end else begin
			wr_addr = count_q[AW-1:0];
			wr_data = in_rec;
		end
	end

	assign we0 = (in_fire && stored) || ((state_q == ST_MERGE) && src_q);
	assign we1 = (state_q == ST_MERGE) && !src_q;

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[wr_addr] <= wr_data;
		end
		if (we1) begin
			mem1[wr_addr] <= wr_data;
		end
		rd0_q <= mem0[rd_addr];
		rd1_q <= mem1[rd_addr];
	end

	// Head and output payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_CAPTURE) begin
			if (need_l_q) begin
				head_l_q <= rd_data;
			end else begin
				head_r_q <= rd_data;
			end
		end
		if (state_q == ST_EMIT_WAIT) begin
			out_rec_q  <= rd_data;
			out_last_q <= (CNT_W'(emit_idx_q + 1'b1) == count_q);
		end
	end

	// Sequencer: load the set, run the bottom-up merge passes, then stream results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			src_q       <= 1'b0;
			w_q         <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			need_l_q    <= 1'b0;
			need_r_q    <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (stored) begin
							count_q <= count_q + 1'b1;
						end else begin
							overflow_q <= 1'b1;
						end
						if (records.last_in) begin
							src_q      <= 1'b0;
							w_q        <= SW'(1);
							lo_q       <= '0;
							emit_idx_q <= '0;
							// A single record needs no merging at all.
							if ((count_q + CNT_W'(stored)) > CNT_W'(1)) begin
								state_q <= ST_SEG;
							end else begin
								state_q <= ST_EMIT_RD;
							end
						end
					end
				end
				ST_SEG: begin
					mid_q    <= seg_mid;
					hi_q     <= seg_hi;
					i_q      <= lo_q;
					j_q      <= seg_mid;
					k_q      <= lo_q;
					need_l_q <= 1'b1;
					need_r_q <= (seg_mid < seg_hi);
					state_q  <= ST_FETCH;
				end
				ST_FETCH: begin
					if (need_l_q || need_r_q) begin
						state_q <= ST_CAPTURE;
					end else begin
						state_q <= ST_PROD;
					end
				end
				ST_CAPTURE: begin
					if (need_l_q) begin
						need_l_q <= 1'b0;
					end else begin
						need_r_q <= 1'b0;
					end
					state_q <= ST_FETCH;
				end
				ST_PROD: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (take_left) begin
						i_q      <= i_next;
						need_l_q <= (i_next < mid_q);
					end else begin
						j_q      <= j_next;
						need_r_q <= (j_next < hi_q);
					end
					k_q <= k_next;
					if (k_next == hi_q) begin
						if (lo_next >= n_ext) begin
							// Pass complete: the written memory becomes the source.
							src_q <= !src_q;
							w_q   <= w_next;
							lo_q  <= '0;
							if (w_next >= n_ext) begin
								state_q <= ST_EMIT_RD;
							end else begin
								state_q <= ST_SEG;
							end
						end else begin
							lo_q    <= lo_next;
							state_q <= ST_SEG;
						end
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_HOLD;
				end
				ST_EMIT_HOLD: begin
					if (sorted.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_LOAD;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
							state_q    <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output side: the result register holds each record until its transfer.
	assign sorted.valid        = out_valid_q;
	assign sorted.out_points   = out_rec_q.points;
	assign sorted.out_scored   = out_rec_q.scored;
	assign sorted.out_conceded = out_rec_q.conceded;
	assign sorted.out_id       = out_rec_q.record_id;
	assign sorted.last_out     = out_last_q;
	assign sorted.dropped      = overflow_q;

endmodule
